@@ design/dltq_pkg.sv @@
// Package for the delta-list timer queue: request/response payload structs,
// request and status codes, cell command struct, parameter defaults.
// No dependencies.
package dltq_pkg;

   localparam int DEPTH_DEF     = 16;
   localparam int TIME_BITS_DEF = 16;
   localparam int ID_BITS_DEF   = 16;

   // request codes
   localparam logic [1:0] REQ_START  = 2'd0;
   localparam logic [1:0] REQ_CANCEL = 2'd1;
   localparam logic [1:0] REQ_TICK   = 2'd2;

   // status codes
   localparam logic [2:0] ST_STARTED   = 3'd0;
   localparam logic [2:0] ST_CANCELLED = 3'd1;
   localparam logic [2:0] ST_EXPIRED   = 3'd2;
   localparam logic [2:0] ST_NONE_DUE  = 3'd3;
   localparam logic [2:0] ST_FULL      = 3'd4;
   localparam logic [2:0] ST_NOT_FOUND = 3'd5;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [15:0] timer_id;
      logic [15:0] duration_ticks;
   } dltq_req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [15:0] result_id;
      logic        last_result;
   } dltq_rsp_type;

   // per-cycle command to every cell of the chain
   typedef struct packed {
      logic shift;   // all cells take their neighbor toward the tail
      logic push;    // with shift: the tail cell takes the broadcast entry
      logic append;  // no shift: the cell just past the tail takes the broadcast entry
   } dltq_cmd_type;

endpackage

@@ design/dltq_cell.sv @@
// One storage cell of the timer chain: holds one (delta, id) entry.
// Depends on dltq_pkg.
module dltq_cell #(
   parameter int IDX       = 0,
   parameter int LEN_BITS  = 5,
   parameter int TIME_BITS = 16,
   parameter int ID_BITS   = 16
) (
   input  logic                  clock,
   input  dltq_pkg::dltq_cmd_type cmd,
   input  logic [LEN_BITS-1:0]   len,
   input  logic [TIME_BITS-1:0]  nxt_delta,
   input  logic [ID_BITS-1:0]    nxt_id,
   input  logic [TIME_BITS-1:0]  y_delta,
   input  logic [ID_BITS-1:0]    y_id,
   output logic [TIME_BITS-1:0]  delta,
   output logic [ID_BITS-1:0]    id
);
   import dltq_pkg::*;

   logic [TIME_BITS-1:0] delta_ff, delta_in;
   logic [ID_BITS-1:0]   id_ff, id_in;
   logic                 is_tail, is_next;

   assign is_tail = (len == LEN_BITS'(IDX + 1));
   assign is_next = (len == LEN_BITS'(IDX));

   always_comb begin
      delta_in = delta_ff;
      id_in    = id_ff;
      if (cmd.shift) begin
         if (cmd.push && is_tail) begin
            delta_in = y_delta;
            id_in    = y_id;
         end else begin
            delta_in = nxt_delta;
            id_in    = nxt_id;
         end
      end else if (cmd.append && is_next) begin
         delta_in = y_delta;
         id_in    = y_id;
      end
   end

   always_ff @(posedge clock) begin
      delta_ff <= delta_in;
      id_ff    <= id_in;
   end

   assign delta = delta_ff;
   assign id    = id_ff;

endmodule

@@ design/dltq_ctrl.sv @@
// Sequencer of the timer queue: rotates the cell ring once per request,
// inserting, removing or expiring entries at the head. Holds the entry count.
// Depends on dltq_pkg.
module dltq_ctrl #(
   parameter int LEN_BITS  = 5,
   parameter int DEPTH     = 16,
   parameter int TIME_BITS = 16,
   parameter int ID_BITS   = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  dltq_pkg::dltq_req_type req_data,
   output logic                   req_stall,
   input  logic [TIME_BITS-1:0]   head_delta,
   input  logic [ID_BITS-1:0]     head_id,
   input  logic                   out_free,
   output dltq_pkg::dltq_cmd_type cmd,
   output logic [LEN_BITS-1:0]    len,
   output logic [TIME_BITS-1:0]   y_delta,
   output logic [ID_BITS-1:0]     y_id,
   output logic                   res_valid,
   output dltq_pkg::dltq_rsp_type res_data
);
   import dltq_pkg::*;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_RUN  = 2'd1;
   localparam logic [1:0] S_DONE = 2'd2;

   localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

   logic [1:0]           state_ff, state_in;
   logic [1:0]           op_ff, op_in;
   logic [ID_BITS-1:0]   tid_ff, tid_in;
   logic [TIME_BITS-1:0] rem_ff, rem_in;      // start: remaining delay; cancel: folded delay
   logic [LEN_BITS-1:0]  steps_ff, steps_in;
   logic [LEN_BITS-1:0]  len_ff, len_in;
   logic                 flag_ff, flag_in;    // inserted / found / decremented
   logic                 lead_ff, lead_in;    // tick: still within leading due entries
   logic                 pend_v_ff, pend_v_in;
   logic [ID_BITS-1:0]   pend_id_ff, pend_id_in;
   logic [2:0]           fin_status_ff, fin_status_in;
   logic [15:0]          fin_id_ff, fin_id_in;

   logic                 accept;
   logic [TIME_BITS-1:0] dur_sat;
   logic [TIME_BITS:0]   fold_sum;
   logic [TIME_BITS-1:0] fold_sat;
   logic [TIME_BITS-1:0] tick_d;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign len       = len_ff;

   always_comb begin
      if (33'(req_data.duration_ticks) > 33'(TIME_MAX)) begin
         dur_sat = TIME_MAX;
      end else begin
         dur_sat = TIME_BITS'(req_data.duration_ticks);
      end
   end

   assign fold_sum = (TIME_BITS+1)'(rem_ff) + (TIME_BITS+1)'(head_delta);
   assign fold_sat = fold_sum[TIME_BITS] ? TIME_MAX : fold_sum[TIME_BITS-1:0];
   assign tick_d   = (!flag_ff && head_delta != '0) ? head_delta - 1'b1 : head_delta;

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      tid_in        = tid_ff;
      rem_in        = rem_ff;
      steps_in      = steps_ff;
      len_in        = len_ff;
      flag_in       = flag_ff;
      lead_in       = lead_ff;
      pend_v_in     = pend_v_ff;
      pend_id_in    = pend_id_ff;
      fin_status_in = fin_status_ff;
      fin_id_in     = fin_id_ff;
      cmd           = '0;
      y_delta       = head_delta;
      y_id          = head_id;
      res_valid     = 1'b0;
      res_data      = '0;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in     = req_data.req_type;
               tid_in    = ID_BITS'(req_data.timer_id);
               rem_in    = '0;
               steps_in  = len_ff;
               flag_in   = 1'b0;
               lead_in   = 1'b1;
               pend_v_in = 1'b0;
               fin_id_in = 16'(ID_BITS'(req_data.timer_id));
               case (req_data.req_type)
                  REQ_START: begin
                     rem_in = dur_sat;
                     if (len_ff >= LEN_BITS'(DEPTH)) begin
                        fin_status_in = ST_FULL;
                        state_in      = S_DONE;
                     end else begin
                        state_in = S_RUN;
                     end
                  end
                  REQ_CANCEL, REQ_TICK: begin
                     state_in = S_RUN;
                  end
                  default: begin
                     fin_status_in = ST_NONE_DUE;
                     fin_id_in     = '0;
                     state_in      = S_DONE;
                  end
               endcase
            end
         end

         S_RUN: begin
            case (op_ff)
               REQ_START: begin
                  if (steps_ff == '0) begin
                     if (!flag_ff) begin
                        cmd.append = 1'b1;
                        y_delta    = rem_ff;
                        y_id       = tid_ff;
                        len_in     = len_ff + 1'b1;
                     end
                     fin_status_in = ST_STARTED;
                     state_in      = S_DONE;
                  end else if (!flag_ff && rem_ff < head_delta) begin
                     // new entry goes before the head entry
                     cmd.append = 1'b1;
                     y_delta    = rem_ff;
                     y_id       = tid_ff;
                     len_in     = len_ff + 1'b1;
                     flag_in    = 1'b1;
                  end else if (!flag_ff) begin
                     cmd.shift = 1'b1;
                     cmd.push  = 1'b1;
                     rem_in    = rem_ff - head_delta;
                     steps_in  = steps_ff - 1'b1;
                  end else begin
                     // entry right after the insert loses the inserted delay
                     cmd.shift = 1'b1;
                     cmd.push  = 1'b1;
                     y_delta   = head_delta - rem_ff;
                     rem_in    = '0;
                     steps_in  = steps_ff - 1'b1;
                  end
               end

               REQ_CANCEL: begin
                  if (steps_ff == '0) begin
                     fin_status_in = flag_ff ? ST_CANCELLED : ST_NOT_FOUND;
                     state_in      = S_DONE;
                  end else if (head_id == tid_ff) begin
                     cmd.shift = 1'b1;
                     len_in    = len_ff - 1'b1;
                     rem_in    = fold_sat;
                     flag_in   = 1'b1;
                     steps_in  = steps_ff - 1'b1;
                  end else begin
                     cmd.shift = 1'b1;
                     cmd.push  = 1'b1;
                     y_delta   = fold_sat;
                     rem_in    = '0;
                     steps_in  = steps_ff - 1'b1;
                  end
               end

               REQ_TICK: begin
                  if (steps_ff == '0) begin
                     fin_status_in = pend_v_ff ? ST_EXPIRED : ST_NONE_DUE;
                     fin_id_in     = pend_v_ff ? 16'(pend_id_ff) : 16'd0;
                     state_in      = S_DONE;
                  end else if (lead_ff && tick_d == '0) begin
                     // due entry: the one held back is now known not to be last
                     if (!pend_v_ff || out_free) begin
                        res_valid            = pend_v_ff;
                        res_data.status      = ST_EXPIRED;
                        res_data.result_id   = 16'(pend_id_ff);
                        res_data.last_result = 1'b0;
                        pend_v_in  = 1'b1;
                        pend_id_in = head_id;
                        cmd.shift  = 1'b1;
                        len_in     = len_ff - 1'b1;
                        flag_in    = flag_ff | (head_delta != '0);
                        steps_in   = steps_ff - 1'b1;
                     end
                  end else begin
                     lead_in   = 1'b0;
                     cmd.shift = 1'b1;
                     cmd.push  = 1'b1;
                     y_delta   = tick_d;
                     flag_in   = flag_ff | (head_delta != '0);
                     steps_in  = steps_ff - 1'b1;
                  end
               end

               default: begin
                  state_in = S_DONE;
               end
            endcase
         end

         S_DONE: begin
            if (out_free) begin
               res_valid            = 1'b1;
               res_data.status      = fin_status_ff;
               res_data.result_id   = fin_id_ff;
               res_data.last_result = 1'b1;
               state_in             = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         len_ff   <= '0;
      end else begin
         state_ff <= state_in;
         len_ff   <= len_in;
      end
      op_ff         <= op_in;
      tid_ff        <= tid_in;
      rem_ff        <= rem_in;
      steps_ff      <= steps_in;
      flag_ff       <= flag_in;
      lead_ff       <= lead_in;
      pend_v_ff     <= pend_v_in;
      pend_id_ff    <= pend_id_in;
      fin_status_ff <= fin_status_in;
      fin_id_ff     <= fin_id_in;
   end

endmodule

@@ design/delta_list_timer_queue.sv @@
// Top level of the delta-list timer queue: ring of storage cells, sequencer,
// response output register.
// Depends on dltq_pkg, dltq_cell, dltq_ctrl.
//
// Up to DEPTH pending timers are kept in expiry order in a chain of cells,
// each holding one delay relative to the entry ahead of it. Every start,
// cancel or tick request rotates the occupied part of the chain once through
// the head cell, where the sequencer inserts, folds away or expires entries.
// Between acceptance and the final response transaction the ring moves one
// entry per cycle past the head, except that a tick waits on rsp_stall for
// every expired timer beyond the first; a start that inserts before an
// existing entry appends it in a step of its own, without moving the ring.
// An unknown request type and a start on a full store answer without
// rotating the chain. req_stall is high
// while a request is in work; one finished response can wait in the output
// register while the next request is accepted. Each request yields exactly
// one response with last_result set, preceded for a tick by one response
// per further expired timer. No clearing pass is needed after reset.
module delta_list_timer_queue #(
   parameter int DEPTH     = dltq_pkg::DEPTH_DEF,
   parameter int TIME_BITS = dltq_pkg::TIME_BITS_DEF,
   parameter int ID_BITS   = dltq_pkg::ID_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  dltq_pkg::dltq_req_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output dltq_pkg::dltq_rsp_type rsp_data
);
   import dltq_pkg::*;

   localparam int LEN_BITS = $clog2(DEPTH + 1);

   // chain contents; the extra slot past the end feeds the last cell
   logic [TIME_BITS-1:0] cell_delta [DEPTH+1];
   logic [ID_BITS-1:0]   cell_id    [DEPTH+1];

   dltq_cmd_type         cmd;
   logic [LEN_BITS-1:0]  len;
   logic [TIME_BITS-1:0] y_delta;
   logic [ID_BITS-1:0]   y_id;
   logic                 res_valid;
   dltq_rsp_type         res_data;
   logic                 out_free;

   logic                 rsp_valid_ff, rsp_valid_in;
   dltq_rsp_type         rsp_data_ff, rsp_data_in;

   assign cell_delta[DEPTH] = '0;
   assign cell_id[DEPTH]    = '0;

   // output register is free when empty or being taken this cycle
   assign out_free = !rsp_valid_ff || !rsp_stall;

   dltq_ctrl #(
      .LEN_BITS  (LEN_BITS),
      .DEPTH     (DEPTH),
      .TIME_BITS (TIME_BITS),
      .ID_BITS   (ID_BITS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_data   (req_data),
      .req_stall  (req_stall),
      .head_delta (cell_delta[0]),
      .head_id    (cell_id[0]),
      .out_free   (out_free),
      .cmd        (cmd),
      .len        (len),
      .y_delta    (y_delta),
      .y_id       (y_id),
      .res_valid  (res_valid),
      .res_data   (res_data)
   );

   // cell 0 is the head; data moves toward it on every shift
   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      dltq_cell #(
         .IDX       (g),
         .LEN_BITS  (LEN_BITS),
         .TIME_BITS (TIME_BITS),
         .ID_BITS   (ID_BITS)
      ) u_cell (
         .clock     (clock),
         .cmd       (cmd),
         .len       (len),
         .nxt_delta (cell_delta[g+1]),
         .nxt_id    (cell_id[g+1]),
         .y_delta   (y_delta),
         .y_id      (y_id),
         .delta     (cell_delta[g]),
         .id        (cell_id[g])
      );
   end

   // response output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (res_valid) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res_data;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // sequencer never overwrites a response that is still waiting
   a_no_overwrite : assert property (@(posedge clock) disable iff (reset)
      res_valid |-> out_free)
      else $error("response loaded into an occupied output register");

   // entry count stays within the chain
   a_len_bound : assert property (@(posedge clock) disable iff (reset)
      len <= LEN_BITS'(DEPTH))
      else $error("entry count beyond store depth");

   // a response without last_result means its request is still in work
   a_not_last_busy : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.last_result) |-> req_stall)
      else $error("intermediate response while idle");

   // a start accepted on a full chain must not grow it
   a_full_hold : assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_data.req_type == REQ_START
       && len == LEN_BITS'(DEPTH)) |=> (len == LEN_BITS'(DEPTH)))
      else $error("store grew past full");

endmodule

@@ sim/delta_list_timer_queue_test.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for delta_list_timer_queue: directed and random start,
// cancel and tick transactions, checked against a delta-list predictor kept here.
// Depends on dltq_pkg and delta_list_timer_queue.
module delta_list_timer_queue_test;
   import dltq_pkg::*;

   localparam int         DEPTH        = DEPTH_DEF;
   localparam logic [1:0] REQ_UNKNOWN  = 2'd3;  // undefined request code, answered as nothing due
   localparam int         RANDOM_ITEMS = 300;
   localparam int         HOLD_AFTER   = 80;    // accepted requests before the long receiver hold
   localparam int         HOLD_CYCLES  = 300;
   localparam int         SETTLE       = 40;
   localparam int         MAX_REPORTS  = 10;
   localparam int         ID_POOL_SIZE = 12;

   // one request waiting in the sender, optionally held back until all answers are in
   typedef struct {
      dltq_req_type req;
      bit           drain_first;
   } queued_request_type;

   logic         clock     = 1'b0;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   dltq_req_type req_data  = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   dltq_rsp_type rsp_data;

   delta_list_timer_queue u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Timer list predictor: delays relative to the entry ahead, head first.
   // ---------------------------------------------------------------------
   logic [15:0]  timer_delay [DEPTH];
   logic [15:0]  timer_ident [DEPTH];
   int           timer_count = 0;
   dltq_rsp_type owed_responses [$];

   queued_request_type request_queue [$];
   logic [15:0]        id_pool [ID_POOL_SIZE];

   int accepted_items = 0;
   int mismatch_count = 0;

   task automatic owe(input logic [2:0] status, input logic [15:0] id, input logic last);
      dltq_rsp_type r;
      r.status      = status;
      r.result_id   = id;
      r.last_result = last;
      owed_responses.push_back(r);
   endtask

   task automatic drop_entry(input int pos);
      int j;
      for (j = pos; j + 1 < timer_count; j++) begin
         timer_delay[j] = timer_delay[j + 1];
         timer_ident[j] = timer_ident[j + 1];
      end
      timer_count--;
   endtask

   // Update the list for one accepted request and queue the answers it owes.
   task automatic predict_timer_request(input dltq_req_type req);
      int           pos;
      int           j;
      int           expired;
      bit           hit;
      logic [15:0]  left_over;
      logic [16:0]  folded;
      dltq_rsp_type final_rsp;
      case (req.req_type)
         REQ_START: begin
            if (timer_count >= DEPTH) begin
               owe(ST_FULL, req.timer_id, 1'b1);
            end else begin
               // walk past every entry due at the same time or earlier
               pos       = 0;
               left_over = req.duration_ticks;
               while (pos < timer_count && left_over >= timer_delay[pos]) begin
                  left_over -= timer_delay[pos];
                  pos++;
               end
               for (j = timer_count; j > pos; j--) begin
                  timer_delay[j] = timer_delay[j - 1];
                  timer_ident[j] = timer_ident[j - 1];
               end
               timer_delay[pos] = left_over;
               timer_ident[pos] = req.timer_id;
               timer_count++;
               if (pos + 1 < timer_count)
                  timer_delay[pos + 1] -= left_over;
               owe(ST_STARTED, req.timer_id, 1'b1);
            end
         end
         REQ_CANCEL: begin
            j   = 0;
            hit = 1'b0;
            while (j < timer_count) begin
               if (timer_ident[j] == req.timer_id) begin
                  // the follower inherits the removed delay, saturating
                  if (j + 1 < timer_count) begin
                     folded             = {1'b0, timer_delay[j + 1]} + timer_delay[j];
                     timer_delay[j + 1] = folded[16] ? 16'hFFFF : folded[15:0];
                  end
                  drop_entry(j);
                  hit = 1'b1;
               end else begin
                  j++;
               end
            end
            owe(hit ? ST_CANCELLED : ST_NOT_FOUND, req.timer_id, 1'b1);
         end
         REQ_TICK: begin
            // leading zero delays are already due; lower the first nonzero one
            for (j = 0; j < timer_count; j++) begin
               if (timer_delay[j] != 16'd0) begin
                  timer_delay[j]--;
                  break;
               end
            end
            expired = 0;
            while (timer_count > 0 && timer_delay[0] == 16'd0) begin
               owe(ST_EXPIRED, timer_ident[0], 1'b0);
               drop_entry(0);
               expired++;
            end
            if (expired == 0) begin
               owe(ST_NONE_DUE, 16'd0, 1'b1);
            end else begin
               final_rsp             = owed_responses.pop_back();
               final_rsp.last_result = 1'b1;
               owed_responses.push_back(final_rsp);
            end
         end
         default: owe(ST_NONE_DUE, 16'd0, 1'b1);
      endcase
   endtask

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------
   task automatic queue_request(input logic [1:0] kind, input logic [15:0] id,
                                input logic [15:0] dur, input bit drain_first);
      queued_request_type q;
      q.req.req_type       = kind;
      q.req.timer_id       = id;
      q.req.duration_ticks = dur;
      q.drain_first        = drain_first;
      request_queue.push_back(q);
   endtask

   // mostly a small pool so that cancels and duplicate ids hit
   function automatic logic [15:0] pick_id();
      if ($urandom_range(0, 4) == 0)
         return 16'($urandom);
      return id_pool[$urandom_range(0, ID_POOL_SIZE - 1)];
   endfunction

   // short delays keep timers expiring; a few full-range ones linger
   function automatic logic [15:0] pick_duration();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 85)
         return 16'($urandom_range(0, 6));
      if (roll < 95)
         return 16'($urandom_range(7, 40));
      return 16'($urandom);
   endfunction

   // ---------------------------------------------------------------------
   // Driver: bursts of transactions with random gaps. A valid request is
   // held unchanged until accepted; the predictor runs at acceptance.
   // ---------------------------------------------------------------------
   int gap_left   = 0;
   int burst_left = 1;

   always @(posedge clock) begin : request_driver
      logic               next_valid;
      queued_request_type next_item;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         next_valid = req_valid;
         if (req_valid && !req_stall) begin
            predict_timer_request(req_data);
            accepted_items++;
            next_valid = 1'b0;
         end
         if (!next_valid) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (request_queue.size() != 0 &&
                         !(request_queue[0].drain_first && owed_responses.size() != 0)) begin
               next_item = request_queue.pop_front();
               req_data  <= next_item.req;
               next_valid = 1'b1;
               if (burst_left > 1) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(1, 24);
                  gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
               end
            end
         end
         req_valid <= next_valid;
      end
   end

   // ---------------------------------------------------------------------
   // Receiver stall: a stall rate chosen anew at random intervals, and
   // once a long hold so the output register fills and req_stall rises
   // while the driver keeps offering.
   // ---------------------------------------------------------------------
   int hold_left    = 0;
   bit hold_done    = 1'b0;
   int pattern_left = 0;
   int stall_pct    = 0;

   always @(posedge clock) begin : response_stall
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (!hold_done && accepted_items >= HOLD_AFTER) begin
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else begin
         if (pattern_left == 0) begin
            pattern_left = $urandom_range(16, 96);
            case ($urandom_range(0, 3))
               0: stall_pct = 0;
               1: stall_pct = 25;
               2: stall_pct = 50;
               default: stall_pct = 85;
            endcase
         end else begin
            pattern_left--;
         end
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: every accepted response against the oldest owed one.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : response_check
      dltq_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (owed_responses.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("%0t: unexpected response status %0d id %h last %b",
                        $time, rsp_data.status, rsp_data.result_id, rsp_data.last_result);
         end else begin
            want = owed_responses.pop_front();
            if (rsp_data.status !== want.status || rsp_data.result_id !== want.result_id ||
                rsp_data.last_result !== want.last_result) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display("%0t: expected status %0d id %h last %b, got status %0d id %h last %b",
                           $time, want.status, want.result_id, want.last_result,
                           rsp_data.status, rsp_data.result_id, rsp_data.last_result);
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus and end of run
   // ---------------------------------------------------------------------
   initial begin : stimulus
      int random_count;
      int roll;
      int burst;
      int k;
      bit drain;
      logic [15:0] shared_dur;

      foreach (id_pool[k])
         id_pool[k] = 16'($urandom);

      // directed: empty list, bad code, unknown cancel
      queue_request(REQ_TICK, 16'h1234, 16'h0000, 1'b0);
      queue_request(REQ_UNKNOWN, 16'($urandom), 16'($urandom), 1'b0);
      queue_request(REQ_CANCEL, 16'hFFFF, 16'h0000, 1'b0);
      // zero duration behaves like one: both expire on the next tick, in order
      queue_request(REQ_START, 16'h0000, 16'h0000, 1'b0);
      queue_request(REQ_START, 16'h8001, 16'h0001, 1'b0);
      queue_request(REQ_TICK, 16'h0000, 16'h0000, 1'b0);
      // cancel removes both copies of an id and folds their delays forward
      queue_request(REQ_START, 16'h0003, 16'h0005, 1'b0);
      queue_request(REQ_START, 16'h0003, 16'h0002, 1'b0);
      queue_request(REQ_START, 16'h0004, 16'h0000, 1'b0);
      queue_request(REQ_CANCEL, 16'h0003, 16'h0000, 1'b0);
      queue_request(REQ_START, 16'hFFFF, 16'hFFFF, 1'b1);
      // fill with ties, then one start too many, then a tick emitting fifteen
      for (k = 0; k < DEPTH - 2; k++)
         queue_request(REQ_START, 16'h5A00 + 16'(k), 16'h0000, 1'b0);
      queue_request(REQ_START, 16'hA5A5, 16'h0003, 1'b0);
      queue_request(REQ_TICK, 16'h0000, 16'h0000, 1'b0);
      queue_request(REQ_CANCEL, 16'hFFFF, 16'h0000, 1'b0);

      // random traffic, mostly well-formed start/tick/cancel mixes
      random_count = 0;
      while (random_count < RANDOM_ITEMS) begin
         roll  = $urandom_range(0, 99);
         drain = ($urandom_range(0, 49) == 0);
         if (roll < 44) begin
            queue_request(REQ_START, pick_id(), pick_duration(), drain);
            random_count++;
         end else if (roll < 70) begin
            queue_request(REQ_TICK, 16'($urandom), 16'($urandom), drain);
            random_count++;
         end else if (roll < 84) begin
            queue_request(REQ_CANCEL, pick_id(), 16'($urandom), drain);
            random_count++;
         end else if (roll < 87) begin
            queue_request(REQ_UNKNOWN, 16'($urandom), 16'($urandom), drain);
            random_count++;
         end else begin
            // several timers sharing one deadline, then ticks until they fire
            burst      = $urandom_range(2, 10);
            shared_dur = 16'($urandom_range(0, 3));
            repeat (burst) begin
               queue_request(REQ_START, pick_id(), shared_dur, 1'b0);
               random_count++;
            end
            repeat (int'(shared_dur) + 1) begin
               queue_request(REQ_TICK, 16'h0000, 16'h0000, 1'b0);
               random_count++;
            end
         end
      end

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      while (request_queue.size() != 0 || req_valid)
         @(posedge clock);
      while (owed_responses.size() != 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);

      if (mismatch_count == 0)
         $display("delta_list_timer_queue test passed");
      else
         $display("delta_list_timer_queue test failed");
      $finish;
   end

   // hard stop well beyond the slowest legal run
   initial begin : watchdog
      #10_000_000;
      $display("delta_list_timer_queue test failed");
      $finish;
   end

endmodule
